// ===== rtl/core/ubds_pkg.sv =====
package ubds_pkg;

  localparam int unsigned PclkW  = 30;
  localparam int unsigned BaudW  = 21;
  localparam int unsigned DvdW   = 47;  // pclk * 100000 < 2^47
  localparam int unsigned DvsW   = 32;  // coef * baud < 2^32
  localparam int unsigned DivCntW = $clog2(DvdW + 1);
  localparam int unsigned ErrW   = 17;
  localparam int unsigned QW     = 25;  // pclk*1e5/ed < 1e5*257
  localparam int unsigned EdW    = 30;  // ed <= pclk
  localparam int unsigned MstepW = PclkW - 8;
  localparam int unsigned EntryCount = 9;
  localparam int unsigned EntryW = $clog2(EntryCount);

  localparam logic [PclkW-1:0] PclkReset = PclkW'(100000000);
  localparam logic [ErrW-1:0]  ErrScale  = ErrW'(100000);
  localparam logic [ErrW-1:0]  ErrLimit  = ErrW'(10000);
  localparam logic [7:0]       DivMax    = 8'd255;
  localparam logic [8:0]       ModMin    = 9'd128;
  localparam logic [8:0]       ModMax    = 9'd256;

  typedef struct packed {
    logic       dbl;
    logic       half;
    logic [1:0] sel;
    logic [3:0] shift;  // log2 of coefficient
  } presc_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic            failed;
    logic [ErrW-1:0] error_scaled;
    logic [8:0]      modulation_value;
    logic            modulation_enable;
    logic            base_clock_half;
    logic            double_speed;
    logic [1:0]      clock_select;
    logic [7:0]      divider_value;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_ENTRY, S_CNT_WAIT, S_ED, S_Q_START, S_Q_WAIT,
    S_M_START, S_M_WAIT, S_MMUL, S_EVAL, S_NEXT, S_DONE
  } seq_state_e;

  function automatic presc_t presc_entry(input logic [EntryW-1:0] idx);
    presc_t p;
    p.shift = 4'(idx) + 4'd3;
    case (idx)
      4'd0:    begin p.dbl = 1'b1; p.half = 1'b1; p.sel = 2'd0; end
      4'd1:    begin p.dbl = 1'b1; p.half = 1'b0; p.sel = 2'd0; end
      4'd2:    begin p.dbl = 1'b0; p.half = 1'b0; p.sel = 2'd0; end
      4'd3:    begin p.dbl = 1'b1; p.half = 1'b0; p.sel = 2'd1; end
      4'd4:    begin p.dbl = 1'b0; p.half = 1'b0; p.sel = 2'd1; end
      4'd5:    begin p.dbl = 1'b1; p.half = 1'b0; p.sel = 2'd2; end
      4'd6:    begin p.dbl = 1'b0; p.half = 1'b0; p.sel = 2'd2; end
      4'd7:    begin p.dbl = 1'b1; p.half = 1'b0; p.sel = 2'd3; end
      default: begin p.dbl = 1'b0; p.half = 1'b0; p.sel = 2'd3; end
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/uart_baud_divisor_search.sv =====
// UART baud divisor search.
// Slave stream: one transaction carries a requested baud rate. The block
// tries nine prescaler entries and, where pclk / (coef * baud) is 1..256,
// divider values below it, counting down; first lowest error is kept.
// Master stream: one result transaction per request (divider, clock
// select, prescaler bits, modulation, error, failed flag).
// cfg_we_i / cfg_wdata_i write the peripheral clock frequency; only while
// the block is idle.
// One shared divider does all divisions. Each entry takes one division
// (none for a zero baud), each candidate two, or one when pclk < 256.
// Divider counts halve from entry to entry, so at most 511 candidates
// are tried per request.
// One request is in flight at a time; s_axis_tready is high only while
// the search engine is idle.
// The result sits in an output register; while the receiver stalls the
// engine can already take and search the next request, then holds that
// result until the register frees.
// Reset: clock register returns to 100 MHz, no result pending.
module uart_baud_divisor_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [29:0] cfg_wdata_i,   // pclk_hz
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [20:0] baud_rate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] divider_value, [9:8] clock_select, [10] double_speed,
  // [11] base_clock_half, [12] modulation_enable, [21:13] modulation_value,
  // [38:22] error_scaled, [39] failed
  output logic [39:0] m_axis_tdata
);
  import ubds_pkg::*;

  logic [PclkW-1:0] pclk_q;
  logic             idle, res_valid, res_ready, out_valid_q;
  result_t          res, out_q;

  ubds_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && idle),
    .baud_i      (s_axis_tdata[BaudW-1:0]),
    .pclk_i      (pclk_q),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pclk_q      <= PclkReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) pclk_q <= cfg_wdata_i;
      if (res_ready) out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign s_axis_tready = idle;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== rtl/core/ubds_div.sv =====
module ubds_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ubds_pkg::div_req_t req_i,
  output ubds_pkg::div_rsp_t rsp_o
);
  import ubds_pkg::*;

  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvdW-1:0]    quo_q;
  logic [DvsW-1:0]    dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DvsW:0]      rem_sh, rem_sub;
  logic               ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, quo_q[DvdW-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    rem_d   = ge ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DvdW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/core/ubds_seq.sv =====
module ubds_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ubds_pkg::BaudW-1:0] baud_i,
  input  logic [ubds_pkg::PclkW-1:0] pclk_i,
  output logic                      idle_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output ubds_pkg::result_t         res_o
);
  import ubds_pkg::*;

  seq_state_e state_q, state_d;

  logic [BaudW-1:0]  baud_q;
  logic [DvdW-1:0]   pscaled_q;
  logic [MstepW-1:0] mstep_q;
  logic [EntryW-1:0] entry_q;
  logic [DvsW-1:0]   divisor_q;
  logic [8:0]        cnt_q;
  logic [EdW-1:0]    ed_q;
  logic [QW-1:0]     q_q;
  logic [8:0]        m_q;
  logic              mval_q;
  logic [QW+8:0]     qm_q;

  logic [ErrW-1:0] min_err_q;
  logic [7:0]      best_div_q;
  logic [8:0]      best_mod_q;
  logic            best_modon_q, best_dbl_q, best_half_q;
  logic [1:0]      best_sel_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  presc_t          pe;
  logic [DvsW-1:0] divisor_cur;
  logic [DvsW+8:0] ed_full;
  logic            cnt_ok, m_ok, last_entry;
  logic [QW:0]     x_m, am, ab;
  logic [ErrW-1:0] e1, e2;
  logic [7:0]      d1, d2;
  logic [8:0]      mv1, mv2;
  logic            on1, on2, upd1, upd2;
  logic            fail;

  ubds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    pe          = presc_entry(entry_q);
    divisor_cur = DvsW'({11'b0, baud_q} << pe.shift);
    ed_full     = divisor_q * cnt_q;
    cnt_ok      = (div_rsp.quotient != '0) && (div_rsp.quotient <= DvdW'(256));
    m_ok        = (div_rsp.quotient >= DvdW'(ModMin)) && (div_rsp.quotient <= DvdW'(ModMax));
    last_entry  = entry_q == EntryW'(EntryCount - 1);
  end

  // candidate evaluation: modulated variant first, then the plain one
  always_comb begin
    x_m = qm_q[QW+8:8];
    am  = (x_m >= (QW+1)'(ErrScale)) ? x_m - (QW+1)'(ErrScale) : (QW+1)'(ErrScale) - x_m;
    ab  = ({1'b0, q_q} >= (QW+1)'(ErrScale)) ? {1'b0, q_q} - (QW+1)'(ErrScale)
                                             : (QW+1)'(ErrScale) - {1'b0, q_q};
    upd1 = mval_q && (am < (QW+1)'(min_err_q));
    e1  = upd1 ? am[ErrW-1:0] : min_err_q;
    d1  = upd1 ? cnt_q[7:0] : best_div_q;
    mv1 = upd1 ? m_q : best_mod_q;
    on1 = upd1 ? 1'b1 : best_modon_q;
    upd2 = ab < (QW+1)'(e1);
    e2  = upd2 ? ab[ErrW-1:0] : e1;
    d2  = upd2 ? cnt_q[7:0] : d1;
    mv2 = upd2 ? 9'd0 : mv1;
    on2 = upd2 ? 1'b0 : on1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (start_i) state_d = S_INIT;
      S_INIT:     state_d = S_ENTRY;
      S_ENTRY:    state_d = (baud_q == '0) ? S_NEXT : S_CNT_WAIT;
      S_CNT_WAIT: if (div_rsp.done) state_d = cnt_ok ? S_ED : S_NEXT;
      S_ED:       state_d = S_Q_START;
      S_Q_START:  state_d = S_Q_WAIT;
      S_Q_WAIT:   if (div_rsp.done) state_d = (mstep_q != '0) ? S_M_START : S_EVAL;
      S_M_START:  state_d = S_M_WAIT;
      S_M_WAIT:   if (div_rsp.done) state_d = S_MMUL;
      S_MMUL:     state_d = S_EVAL;
      S_EVAL:     state_d = ((e2 == '0) || (cnt_q == '0)) ? S_NEXT : S_ED;
      S_NEXT:     state_d = last_entry ? S_DONE : S_ENTRY;
      S_DONE:     if (res_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state_q)
      S_ENTRY: begin
        div_req.start    = baud_q != '0;
        div_req.dividend = DvdW'(pclk_i);
        div_req.divisor  = divisor_cur;
      end
      S_Q_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = pscaled_q;
        div_req.divisor  = DvsW'(ed_q);
      end
      S_M_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = DvdW'(ed_q);
        div_req.divisor  = DvsW'(mstep_q);
      end
      default: div_req = '0;
    endcase
  end

  always_comb begin
    fail                    = min_err_q > ErrLimit;
    idle_o                  = state_q == S_IDLE;
    res_valid_o             = state_q == S_DONE;
    res_o.failed            = fail;
    res_o.error_scaled      = min_err_q;
    res_o.modulation_enable = best_modon_q && !fail;
    res_o.modulation_value  = (best_modon_q && !fail) ? best_mod_q : 9'd0;
    res_o.base_clock_half   = best_half_q;
    res_o.double_speed      = best_dbl_q;
    res_o.clock_select      = fail ? 2'd0 : best_sel_q;
    res_o.divider_value     = fail ? 8'd0 : best_div_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (start_i) baud_q <= baud_i;
      S_INIT: begin
        pscaled_q    <= DvdW'(pclk_i) * DvdW'(ErrScale);
        mstep_q      <= pclk_i[PclkW-1:8];
        entry_q      <= '0;
        min_err_q    <= ErrScale;
        best_div_q   <= DivMax;
        best_mod_q   <= '0;
        best_modon_q <= 1'b0;
        best_sel_q   <= '0;
        best_dbl_q   <= 1'b0;
        best_half_q  <= 1'b0;
      end
      S_ENTRY: divisor_q <= divisor_cur;
      S_CNT_WAIT: if (div_rsp.done) cnt_q <= div_rsp.quotient[8:0];
      S_ED: begin
        ed_q  <= ed_full[EdW-1:0];
        cnt_q <= cnt_q - 9'd1;
      end
      S_Q_WAIT: if (div_rsp.done) begin
        q_q    <= div_rsp.quotient[QW-1:0];
        mval_q <= 1'b0;
      end
      S_M_WAIT: if (div_rsp.done) begin
        m_q    <= div_rsp.quotient[8:0];
        mval_q <= m_ok;
      end
      S_MMUL: qm_q <= q_q * m_q;
      S_EVAL: begin
        min_err_q    <= e2;
        best_div_q   <= d2;
        best_mod_q   <= mv2;
        best_modon_q <= on2;
        if (upd1 || upd2) begin
          best_sel_q  <= pe.sel;
          best_dbl_q  <= pe.dbl;
          best_half_q <= pe.half;
        end
      end
      S_NEXT: entry_q <= entry_q + EntryW'(1);
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/ubds_checker.sv =====
module ubds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39] |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[9:8] == 2'd0 && !m_axis_tdata[12])
    else $error("failed result not cleared");

  a_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[21:13] == 9'd0)
    else $error("modulation value without enable");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[39] |-> m_axis_tdata[38:22] <= 17'd10000)
    else $error("error above limit not flagged");

endmodule

bind uart_baud_divisor_search ubds_checker u_ubds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_uart_baud_divisor_search.sv =====
`timescale 1ns / 1ps

module tb_uart_baud_divisor_search;
  import ubds_pkg::*;

  localparam int unsigned StallLimit = 300000;
  localparam int unsigned TailCycles = 300;
  localparam int unsigned RandItems  = 80;

  typedef enum logic [1:0] { ROW_CFG, ROW_BAUD, ROW_BAUD_KNOWN } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [29:0] value;
    result_t     known;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [29:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  logic [29:0] pclk_model;
  result_t     expected_results[$];
  int          mismatches = 0;
  int          src_idle_pct = 9;
  int          sink_idle_pct = 51;
  int unsigned quiet_cycles = 0;

  uart_baud_divisor_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Best divider over the nine prescaler entries, first strictly lowest error wins.
  function automatic result_t predict_divisor(input logic [29:0] pclk, input logic [20:0] baud);
    localparam logic [8:0] DblTab = 9'b010101011;
    longint unsigned pc, bd, mstep, dvs, cnt, d, ed, m;
    longint          min_err, bit_err, me, am, ae;
    result_t         r;
    pc = pclk;
    bd = baud;
    mstep = pc / ModMax;
    min_err = ErrScale;
    r = '0;
    r.divider_value = DivMax;
    for (int i = 0; i < EntryCount; i++) begin
      dvs = (64'd8 << i) * bd;
      if (dvs == 0) continue;
      cnt = pc / dvs;
      if (cnt == 0 || cnt > DivMax + 1) continue;
      while (cnt > 0) begin
        cnt--;
        d = cnt;
        ed = dvs * (d + 1);
        bit_err = longint'((pc * ErrScale) / ed) - longint'(ErrScale);
        if (mstep != 0) begin
          m = ed / mstep;
          if (m >= ModMin && m <= ModMax) begin
            me = ((bit_err + longint'(ErrScale)) * longint'(m)) / 256 - longint'(ErrScale);
            am = me < 0 ? -me : me;
            if (am < min_err) begin
              min_err = am;
              r.divider_value = d[7:0];
              r.modulation_value = m[8:0];
              r.modulation_enable = 1'b1;
              r.double_speed = DblTab[i];
              r.base_clock_half = (i == 0);
              r.clock_select = (i < 3) ? 2'd0 : 2'((i - 1) / 2);
            end
          end
        end
        ae = bit_err < 0 ? -bit_err : bit_err;
        if (ae < min_err) begin
          min_err = ae;
          r.divider_value = d[7:0];
          r.modulation_value = '0;
          r.modulation_enable = 1'b0;
          r.double_speed = DblTab[i];
          r.base_clock_half = (i == 0);
          r.clock_select = (i < 3) ? 2'd0 : 2'((i - 1) / 2);
        end
        if (min_err == 0) break;
      end
    end
    r.error_scaled = min_err[ErrW-1:0];
    r.failed = min_err > ErrLimit;
    if (r.failed) begin
      r.divider_value = '0;
      r.clock_select = '0;
      r.modulation_enable = 1'b0;
    end
    if (!r.modulation_enable) r.modulation_value = '0;
    return r;
  endfunction

  // Drops the request and waits until every expected result is in.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  // Called at a falling edge; block is idle once all results are in.
  task automatic write_pclk(input logic [29:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pclk_model = value;
  endtask

  task automatic send_baud(input logic [20:0] baud, input bit known_valid, input result_t known);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, baud};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(known_valid ? known : predict_divisor(pclk_model, baud));
    @(negedge clk_i);
  endtask

  function automatic logic [20:0] pick_baud(input logic [29:0] pclk);
    int unsigned sel, k;
    longint unsigned b;
    sel = $urandom_range(99);
    if (sel < 20) return 21'($urandom_range(2097151));
    k = (sel < 90) ? $urandom_range(24, 1) : $urandom_range(300, 25);
    b = pclk / (8 * k);
    if ($urandom_range(1)) b = b + b * $urandom_range(20) / 1000;
    else b = b - b * $urandom_range(20) / 1000;
    if (b > 2097151) b = 2097151;
    return b[20:0];
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk_i) begin
    result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("divider_value", want.divider_value, got.divider_value);
        check_field("clock_select", want.clock_select, got.clock_select);
        check_field("double_speed", want.double_speed, got.double_speed);
        check_field("base_clock_half", want.base_clock_half, got.base_clock_half);
        check_field("modulation_enable", want.modulation_enable, got.modulation_enable);
        check_field("modulation_value", want.modulation_value, got.modulation_value);
        check_field("error_scaled", want.error_scaled, got.error_scaled);
        check_field("failed", want.failed, got.failed);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t  rows[$];
    result_t    fail_all, exact_mod;
    logic [29:0] phase_pclk [6];
    int         idx;

    fail_all = '0;
    fail_all.error_scaled = ErrScale;
    fail_all.failed = 1'b1;
    // 16 MHz at 1 Mbaud: exact with modulation value 256 taken first
    exact_mod = '0;
    exact_mod.divider_value = 8'd1;
    exact_mod.double_speed = 1'b1;
    exact_mod.base_clock_half = 1'b1;
    exact_mod.modulation_enable = 1'b1;
    exact_mod.modulation_value = ModMax;

    rows.push_back('{ROW_BAUD_KNOWN, 30'd0, fail_all});        // zero baud after reset
    rows.push_back('{ROW_BAUD_KNOWN, 30'd1, fail_all});        // every entry out of reach
    rows.push_back('{ROW_BAUD, 30'd115200, '0});
    rows.push_back('{ROW_BAUD, 30'd2000000, '0});
    rows.push_back('{ROW_BAUD, 30'd9600, '0});
    rows.push_back('{ROW_CFG, 30'd16000000, '0});
    rows.push_back('{ROW_BAUD_KNOWN, 30'd1000000, exact_mod});
    rows.push_back('{ROW_BAUD, 30'd500000, '0});
    rows.push_back('{ROW_BAUD, 30'd2000000, '0});
    rows.push_back('{ROW_CFG, 30'd1000000, '0});
    rows.push_back('{ROW_BAUD, 30'd125000, '0});
    rows.push_back('{ROW_BAUD_KNOWN, 30'd2000000, fail_all});
    rows.push_back('{ROW_BAUD, 30'd3, '0});
    rows.push_back('{ROW_CFG, 30'd200, '0});                   // tiny clock, no modulation
    rows.push_back('{ROW_BAUD, 30'd25, '0});
    rows.push_back('{ROW_BAUD, 30'd1, '0});
    rows.push_back('{ROW_BAUD_KNOWN, 30'd0, fail_all});
    rows.push_back('{ROW_CFG, 30'd1000000000, '0});
    rows.push_back('{ROW_BAUD, 30'd2000000, '0});
    rows.push_back('{ROW_BAUD, 30'd2097151, '0});
    rows.push_back('{ROW_CFG, 30'h3FFFFFFF, '0});
    rows.push_back('{ROW_BAUD, 30'd2097151, '0});
    rows.push_back('{ROW_BAUD, 30'd1398101, '0});

    phase_pclk = '{30'd1000000, 30'd100000000, 30'd16000000, 30'd1000000000,
                   30'd48000000, 30'd0};
    pclk_model = PclkReset;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_pclk(rows[i].value);
      else send_baud(rows[i].value[20:0], rows[i].kind == ROW_BAUD_KNOWN, rows[i].known);
    end

    idx = 0;
    for (int p = 0; p < 6; p++) begin
      write_pclk(p == 5 ? 30'($urandom_range(1000000000, 1000000)) : phase_pclk[p]);
      for (int n = 0; n < RandItems / 6 + 1; n++) begin
        if (idx < RandItems / 3) begin
          src_idle_pct = 9;
          sink_idle_pct = 51;
        end else if (idx < 2 * RandItems / 3) begin
          src_idle_pct = 51;
          sink_idle_pct = 9;
        end else begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
        if (idx == RandItems / 2) drain_results();   // let the pipe empty once
        send_baud(pick_baud(pclk_model), 1'b0, '0);
        idx++;
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
